>>> hw/rtl/sgs_pkg.sv
// Shared types and constants for the streaming 3x3 Sobel gradient block.
package sgs_pkg;

    // Line store geometry
    localparam int MaxWidth   = 256;
    localparam int ColWidth   = $clog2(MaxWidth);
    localparam int RowWidth   = 12;
    localparam int PixWidth   = 8;
    localparam int WidthRegW  = 9;
    localparam int HeightRegW = 13;
    localparam int CfgDataW   = 13;

    // Effective frame size limits
    localparam logic [WidthRegW-1:0]  WidthMin  = WidthRegW'(3);
    localparam logic [WidthRegW-1:0]  WidthMax  = WidthRegW'(MaxWidth);
    localparam logic [HeightRegW-1:0] HeightMin = HeightRegW'(3);
    localparam logic [HeightRegW-1:0] HeightMax = HeightRegW'(4096);

    // Register reset values
    localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(256);
    localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(256);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Two previous columns of the 3x3 window
    typedef struct packed {
        logic [PixWidth-1:0] left_top;
        logic [PixWidth-1:0] left_mid;
        logic [PixWidth-1:0] left_bot;
        logic [PixWidth-1:0] center_top;
        logic [PixWidth-1:0] center_mid;
        logic [PixWidth-1:0] center_bot;
    } window_t;

endpackage

>>> hw/rtl/sgs_kernel.sv
// Combinational Sobel kernel: weighted column/row sums and gradient magnitude.
module sgs_kernel (
    input  sgs_pkg::window_t                win,
    input  logic [sgs_pkg::PixWidth-1:0]    right_top,
    input  logic [sgs_pkg::PixWidth-1:0]    right_mid,
    input  logic [sgs_pkg::PixWidth-1:0]    right_bot,
    output logic [sgs_pkg::PixWidth-1:0]    gradient
);

    logic [sgs_pkg::PixWidth-1:0] sum_right;
    logic [sgs_pkg::PixWidth-1:0] sum_left;
    logic [sgs_pkg::PixWidth-1:0] sum_bot;
    logic [sgs_pkg::PixWidth-1:0] sum_top;
    logic [sgs_pkg::PixWidth-1:0] mag_x;
    logic [sgs_pkg::PixWidth-1:0] mag_y;

    // Weighted sums: each term is pre-shifted, so each sum stays below 254
    assign sum_right = (right_top >> 2) + (right_mid >> 1) + (right_bot >> 2);
    assign sum_left  = (win.left_top >> 2) + (win.left_mid >> 1) + (win.left_bot >> 2);
    assign sum_bot   = (win.left_bot >> 2) + (win.center_bot >> 1) + (right_bot >> 2);
    assign sum_top   = (win.left_top >> 2) + (win.center_top >> 1) + (right_top >> 2);

    // Absolute differences: subtract the smaller sum from the larger
    assign mag_x = (sum_right >= sum_left) ? (sum_right - sum_left) : (sum_left - sum_right);
    assign mag_y = (sum_bot >= sum_top) ? (sum_bot - sum_top) : (sum_top - sum_bot);

    // Merge halved magnitudes; result never exceeds 252
    assign gradient = (mag_x >> 1) + (mag_y >> 1);

endmodule

>>> hw/rtl/sobel_gradient_3x3_stream.sv
// Top level of the streaming 3x3 Sobel gradient block with line stores.
//
// Pixels enter in raster order on the pixel channel (in_valid / in_ready),
// one beat per pixel. Frame size comes from image_width (index 0) and
// image_height (index 1), written through cfg_write_en / cfg_index /
// cfg_data; any write restarts the frame at row 0, column 0. Out-of-range
// sizes are clamped to 3..256 columns and 3..4096 rows.
// Each pixel whose 3x3 window lies inside the frame yields one beat on the
// result channel (out_valid / out_ready): gradient and frame_last, which
// marks the last gradient of the frame. A W x H frame gives (W-2) x (H-2)
// beats; the first two rows and columns give none.
// An accepted pixel is registered in the read stage; its result then passes to the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the dual-port
// line stores (one read and one write per store each cycle) and the one-stage kernel.
// When the receiver stalls, the output register holds its beat and the
// stage behind it fills; in_ready drops only when both are occupied.
// Reset clears counters, window and valid flags and sets the size to
// 256 x 256; line store contents are undefined until the first rows pass.
module sobel_gradient_3x3_stream (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sgs_pkg::PixWidth-1:0]      pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sgs_pkg::PixWidth-1:0]      gradient,
    output logic                              frame_last,
    input  logic                              cfg_write_en,
    input  logic [0:0]                        cfg_index,
    input  logic [sgs_pkg::CfgDataW-1:0]      cfg_data
);

    // Configuration
    logic [sgs_pkg::WidthRegW-1:0]  width_reg;
    logic [sgs_pkg::HeightRegW-1:0] height_reg;
    logic [sgs_pkg::ColWidth-1:0]   col_last;
    logic [sgs_pkg::RowWidth-1:0]   row_last;

    // Position counters
    logic [sgs_pkg::ColWidth-1:0]   col_reg;
    logic [sgs_pkg::ColWidth-1:0]   col_next;
    logic [sgs_pkg::RowWidth-1:0]   row_reg;
    logic [sgs_pkg::RowWidth-1:0]   row_next;

    // Line stores
    logic [sgs_pkg::PixWidth-1:0]   upper_mem  [sgs_pkg::MaxWidth];
    logic [sgs_pkg::PixWidth-1:0]   middle_mem [sgs_pkg::MaxWidth];

    // Read stage
    logic                           rd_valid_reg;
    logic                           rd_valid_next;
    logic [sgs_pkg::PixWidth-1:0]   rd_pixel_reg;
    logic [sgs_pkg::PixWidth-1:0]   rd_top_reg;
    logic [sgs_pkg::PixWidth-1:0]   rd_mid_reg;
    logic [sgs_pkg::ColWidth-1:0]   rd_col_reg;
    logic                           rd_produce_reg;
    logic                           rd_last_reg;

    // Window and result stage
    sgs_pkg::window_t               win_reg;
    sgs_pkg::window_t               win_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [sgs_pkg::PixWidth-1:0]   gradient_reg;
    logic                           frame_last_reg;
    logic [sgs_pkg::PixWidth-1:0]   kernel_gradient;

    logic                           in_accept;
    logic                           rd_advance;
    logic                           rd_emit;

    // Clamp frame size to the supported range and form last indexes
    always_comb
    begin
        if (width_reg < sgs_pkg::WidthMin)
            col_last = sgs_pkg::ColWidth'(sgs_pkg::WidthMin - 1'b1);
        else if (width_reg > sgs_pkg::WidthMax)
            col_last = sgs_pkg::ColWidth'(sgs_pkg::WidthMax - 1'b1);
        else
            col_last = sgs_pkg::ColWidth'(width_reg - 1'b1);

        if (height_reg < sgs_pkg::HeightMin)
            row_last = sgs_pkg::RowWidth'(sgs_pkg::HeightMin - 1'b1);
        else if (height_reg > sgs_pkg::HeightMax)
            row_last = sgs_pkg::RowWidth'(sgs_pkg::HeightMax - 1'b1);
        else
            row_last = sgs_pkg::RowWidth'(height_reg - 1'b1);
    end

    // Handshake: read stage drains when it emits nothing or the output frees up
    assign rd_emit    = rd_valid_reg && rd_produce_reg;
    assign rd_advance = rd_valid_reg && (!rd_produce_reg || !out_valid_reg || out_ready);
    assign in_ready   = !rd_valid_reg || rd_advance;
    assign in_accept  = in_valid && in_ready;

    // Advance raster position on each accepted beat
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Hold configuration; restart the frame on any write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sgs_pkg::WidthReset;
            height_reg <= sgs_pkg::HeightReset;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (sgs_pkg::cfg_reg_t'(cfg_index))
                sgs_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[sgs_pkg::WidthRegW-1:0];
                sgs_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data;
                default:
                    width_reg <= width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Middle store: read old row above, write new pixel, same address
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_mid_reg          <= middle_mem[col_reg];
            middle_mem[col_reg] <= pixel;
        end
    end

    // Upper store: read at accept, write back the middle pixel as it drains
    always_ff @(posedge clk)
    begin
        if (in_accept)
            rd_top_reg <= upper_mem[col_reg];
        if (rd_advance)
            upper_mem[rd_col_reg] <= rd_mid_reg;
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_pixel_reg   <= pixel;
            rd_col_reg     <= col_reg;
            rd_produce_reg <= (col_reg >= sgs_pkg::ColWidth'(2))
                              && (row_reg >= sgs_pkg::RowWidth'(2));
            rd_last_reg    <= (col_reg == col_last) && (row_reg == row_last);
        end
    end

    // Read stage valid
    assign rd_valid_next = in_accept ? 1'b1 : (rd_advance ? 1'b0 : rd_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= rd_valid_next;
    end

    // Gradient from the window and the incoming column
    sgs_kernel u_kernel (
        .win       (win_reg),
        .right_top (rd_top_reg),
        .right_mid (rd_mid_reg),
        .right_bot (rd_pixel_reg),
        .gradient  (kernel_gradient)
    );

    // Shift the window one column as the beat drains
    always_comb
    begin
        win_next = win_reg;
        if (rd_advance)
        begin
            win_next.left_top   = win_reg.center_top;
            win_next.left_mid   = win_reg.center_mid;
            win_next.left_bot   = win_reg.center_bot;
            win_next.center_top = rd_top_reg;
            win_next.center_mid = rd_mid_reg;
            win_next.center_bot = rd_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else
            win_reg <= win_next;
    end

    // Output register: load on emit, drop when taken
    always_comb
    begin
        if (rd_advance && rd_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_advance && rd_emit)
        begin
            gradient_reg   <= kernel_gradient;
            frame_last_reg <= rd_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gradient   = gradient_reg;
    assign frame_last = frame_last_reg;

endmodule
